// ----- src/spi_nor_program_erase_sequencer_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the SPI NOR program/erase sequencer.
// Checks compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SPI_NOR_PROGRAM_ERASE_SEQUENCER_UNIT_ASSERT_SVH
`define SPI_NOR_PROGRAM_ERASE_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property holds at every edge outside reset.
`define SNPE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("snpe assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define SNPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("snpe assertion failed");
`else
`define SNPE_ASSERT(label, clk, rst, prop)
`define SNPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/snpe_pkg.sv -----
// ---------------------------------------------------------------------------
// SPI NOR program/erase sequencer package
// Field widths, command opcodes, result kinds, phase codes and shared types.
// ---------------------------------------------------------------------------
package snpe_pkg;

   // geometry
   localparam int PAGE_BYTES   = 256;
   localparam int ERASE_BYTES  = 4096;
   localparam int ADDRESS_BITS = 24;

   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int ERASE_SHIFT = $clog2(ERASE_BYTES);
   localparam int ADDR_BYTES  = (ADDRESS_BITS + 7) / 8;
   localparam int CHUNK_W     = $clog2(PAGE_BYTES + 1);

   // field widths
   localparam int TYPE_W   = 2;
   localparam int OFFSET_W = 24;
   localparam int LENGTH_W = 25;
   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 3;
   localparam int KIB_W    = 15;
   localparam int KIB_SHIFT = 10;
   localparam int SUM_W    = LENGTH_W + 1;

   localparam logic [OFFSET_W-1:0] ADDR_MASK = OFFSET_W'((64'd1 << ADDRESS_BITS) - 64'd1);
   localparam logic [KIB_W-1:0]    FLASH_KIB_RESET = 15'd4096;

   // results per transaction and result queue
   localparam int MAX_RSP   = ADDR_BYTES + 2;
   localparam int RSP_CNT_W = $clog2(MAX_RSP + 1);
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // request types
   localparam logic [TYPE_W-1:0] REQ_WRITE  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DATA   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_ERASE  = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_STATUS = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_KEEP    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd4;

   // flash opcodes and status bits
   localparam logic [BYTE_W-1:0] OP_RDSR = 8'h05;
   localparam logic [BYTE_W-1:0] OP_WREN = 8'h06;
   localparam logic [BYTE_W-1:0] OP_PP   = 8'h02;
   localparam logic [BYTE_W-1:0] OP_SE   = 8'h20;
   localparam int STATUS_BUSY_BIT = 0;
   localparam int STATUS_WEL_BIT  = 1;

   // sequencer phases
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_BUSY0   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_WEL     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DATA    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_BUSY_OP = 3'd4;

   typedef struct packed {
      logic [TYPE_W-1:0]   req_type;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
      logic [BYTE_W-1:0]   byte_in;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] spi_byte;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase;
      logic                erasing;
      logic [OFFSET_W-1:0] cur_address;
      logic [LENGTH_W-1:0] bytes_remaining;
      logic [CHUNK_W-1:0]  chunk_left;
   } seq_state_type;

endpackage

// ----- src/snpe_step.sv -----
// ---------------------------------------------------------------------------
// Sequencer step
// Decodes one registered transaction against the current phase and produces
// the next sequencer state and up to MAX_RSP result items.
// ---------------------------------------------------------------------------
module snpe_step
   import snpe_pkg::*;
(
   input  seq_state_type           cur_state,
   input  logic [KIB_W-1:0]        flash_kib,
   input  req_item_type            req,
   output seq_state_type           nxt_state,
   output logic [RSP_CNT_W-1:0]    rsp_count,
   output rsp_item_type            rsp_items [MAX_RSP]
);

   function automatic rsp_item_type mk_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] b);
      rsp_item_type item;
      item.kind     = kind;
      item.spi_byte = b;
      item.last     = 1'b0;
      return item;
   endfunction

   logic [SUM_W-1:0]    range_sum;
   logic [SUM_W-1:0]    range_limit;
   logic                bad_req;
   logic [OFFSET_W-1:0] addr_masked;
   logic [CHUNK_W-1:0]  page_room;
   logic                busy;
   logic                wel;
   rsp_item_type        items [MAX_RSP];

   assign range_sum   = SUM_W'(req.offset) + SUM_W'(req.length);
   assign range_limit = SUM_W'({req.offset[0] & 1'b0, flash_kib, {KIB_SHIFT{1'b0}}});
   assign addr_masked = cur_state.cur_address & ADDR_MASK;
   assign page_room   = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(cur_state.cur_address[PAGE_SHIFT-1:0]);
   assign busy        = req.byte_in[STATUS_BUSY_BIT];
   assign wel         = req.byte_in[STATUS_WEL_BIT];

   always_comb begin
      bad_req = range_sum > range_limit;
      if (req.req_type == REQ_ERASE &&
          (req.offset[ERASE_SHIFT-1:0] != '0 || req.length[ERASE_SHIFT-1:0] != '0)) begin
         bad_req = 1'b1;
      end
   end

   always_comb begin
      nxt_state = cur_state;
      rsp_count = '0;
      for (int i = 0; i < MAX_RSP; i++) begin
         items[i] = mk_item(KIND_KEEP, '0);
      end

      unique case (cur_state.phase)
         PH_IDLE: begin
            if (req.req_type == REQ_WRITE || req.req_type == REQ_ERASE) begin
               if (bad_req) begin
                  items[0]  = mk_item(KIND_REJECT, '0);
                  rsp_count = RSP_CNT_W'(1);
               end else if (req.length == '0) begin
                  items[0]  = mk_item(KIND_DONE, '0);
                  rsp_count = RSP_CNT_W'(1);
               end else begin
                  nxt_state.erasing         = (req.req_type == REQ_ERASE);
                  nxt_state.cur_address     = req.offset;
                  nxt_state.bytes_remaining = req.length;
                  nxt_state.phase           = PH_BUSY0;
                  items[0]  = mk_item(KIND_STATUS, OP_RDSR);
                  rsp_count = RSP_CNT_W'(1);
               end
            end
         end
         PH_BUSY0: begin
            if (req.req_type == REQ_STATUS) begin
               if (busy) begin
                  items[0]  = mk_item(KIND_STATUS, OP_RDSR);
                  rsp_count = RSP_CNT_W'(1);
               end else begin
                  items[0]  = mk_item(KIND_RELEASE, OP_WREN);
                  items[1]  = mk_item(KIND_STATUS, OP_RDSR);
                  rsp_count = RSP_CNT_W'(2);
                  nxt_state.phase = PH_WEL;
               end
            end
         end
         PH_WEL: begin
            if (req.req_type == REQ_STATUS) begin
               if (busy) begin
                  items[0]  = mk_item(KIND_STATUS, OP_RDSR);
                  rsp_count = RSP_CNT_W'(1);
               end else if (!wel) begin
                  items[0]  = mk_item(KIND_RELEASE, OP_WREN);
                  items[1]  = mk_item(KIND_STATUS, OP_RDSR);
                  rsp_count = RSP_CNT_W'(2);
               end else begin
                  // opcode, then address most significant byte first
                  items[0] = mk_item(KIND_KEEP, cur_state.erasing ? OP_SE : OP_PP);
                  for (int i = 0; i < ADDR_BYTES; i++) begin
                     items[1+i] = mk_item(
                        (cur_state.erasing && i == ADDR_BYTES - 1) ? KIND_RELEASE : KIND_KEEP,
                        addr_masked[8*(ADDR_BYTES-1-i) +: 8]);
                  end
                  if (cur_state.erasing) begin
                     items[1+ADDR_BYTES] = mk_item(KIND_STATUS, OP_RDSR);
                     rsp_count = RSP_CNT_W'(ADDR_BYTES + 2);
                     nxt_state.cur_address     = cur_state.cur_address + OFFSET_W'(ERASE_BYTES);
                     nxt_state.bytes_remaining = cur_state.bytes_remaining
                                                 - LENGTH_W'(ERASE_BYTES);
                     nxt_state.phase = PH_BUSY_OP;
                  end else begin
                     rsp_count = RSP_CNT_W'(ADDR_BYTES + 1);
                     // stop the chunk at the page boundary
                     if (cur_state.bytes_remaining < LENGTH_W'(page_room)) begin
                        nxt_state.chunk_left = CHUNK_W'(cur_state.bytes_remaining);
                     end else begin
                        nxt_state.chunk_left = page_room;
                     end
                     nxt_state.phase = PH_DATA;
                  end
               end
            end
         end
         PH_DATA: begin
            if (req.req_type == REQ_DATA) begin
               nxt_state.chunk_left      = cur_state.chunk_left - CHUNK_W'(1);
               nxt_state.bytes_remaining = cur_state.bytes_remaining - LENGTH_W'(1);
               nxt_state.cur_address     = cur_state.cur_address + OFFSET_W'(1);
               if (cur_state.chunk_left == CHUNK_W'(1)) begin
                  items[0]  = mk_item(KIND_RELEASE, req.byte_in);
                  items[1]  = mk_item(KIND_STATUS, OP_RDSR);
                  rsp_count = RSP_CNT_W'(2);
                  nxt_state.phase = PH_BUSY_OP;
               end else begin
                  items[0]  = mk_item(KIND_KEEP, req.byte_in);
                  rsp_count = RSP_CNT_W'(1);
               end
            end
         end
         PH_BUSY_OP: begin
            if (req.req_type == REQ_STATUS) begin
               if (busy) begin
                  items[0]  = mk_item(KIND_STATUS, OP_RDSR);
                  rsp_count = RSP_CNT_W'(1);
               end else if (cur_state.bytes_remaining == '0) begin
                  items[0]  = mk_item(KIND_DONE, '0);
                  rsp_count = RSP_CNT_W'(1);
                  nxt_state.phase   = PH_IDLE;
                  nxt_state.erasing = 1'b0;
               end else begin
                  items[0]  = mk_item(KIND_RELEASE, OP_WREN);
                  items[1]  = mk_item(KIND_STATUS, OP_RDSR);
                  rsp_count = RSP_CNT_W'(2);
                  nxt_state.phase = PH_WEL;
               end
            end
         end
         default: begin
            nxt_state.phase = PH_IDLE;
         end
      endcase
   end

   // flag the final item of this transaction
   always_comb begin
      for (int i = 0; i < MAX_RSP; i++) begin
         rsp_items[i]      = items[i];
         rsp_items[i].last = (RSP_CNT_W'(i + 1) == rsp_count);
      end
   end

endmodule

// ----- src/snpe_rsp_fifo.sv -----
// ---------------------------------------------------------------------------
// Result queue
// Takes up to MAX_RSP result items in one cycle and hands them out one per
// cycle in order while pop is high.
// ---------------------------------------------------------------------------
`include "spi_nor_program_erase_sequencer_unit_assert.svh"

module snpe_rsp_fifo
   import snpe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RSP_CNT_W-1:0]   push_count,
   input  rsp_item_type           push_items [MAX_RSP],
   input  logic                   pop,
   output rsp_item_type           head,
   output logic [FIFO_CNT_W-1:0]  count
);

   rsp_item_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;

   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RSP; i++) begin
         if (RSP_CNT_W'(i) < push_count) begin
            mem_ff[wr_ptr_ff + FIFO_PTR_W'(i)] <= push_items[i];
         end
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   `SNPE_ASSERT(a_count_bound, clock, reset, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `SNPE_ASSERT(a_push_fits, clock, reset,
                (push_count == '0) ||
                ((FIFO_CNT_W+1)'(count_ff) + (FIFO_CNT_W+1)'(push_count)
                 <= (FIFO_CNT_W+1)'(FIFO_DEPTH)))
   `SNPE_ASSERT(a_pop_nonempty, clock, reset, !pop || (count_ff != '0))
   `SNPE_ASSERT_NEXT(a_pop_drains, clock, reset, pop && (push_count == '0),
                     count_ff == $past(count_ff) - FIFO_CNT_W'(1))

endmodule

// ----- src/spi_nor_program_erase_sequencer_unit.sv -----
// ---------------------------------------------------------------------------
// SPI NOR program/erase sequencer
// Turns write/erase requests, data bytes and flash status bytes into
// SPI NOR command bytes with chip-select framing.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per write request, data byte, erase request or
//            status byte read back from the flash.
//   rsp_*  : command bytes and completion codes, one per transaction on the
//            result channel; rsp_last marks the final one for a request item.
//   csr_*  : write of flash_kib (capacity in KiB), taken at any cycle; write
//            it only while the sequencer is quiet.
// Flow: a request passes the input register, then the result queue, before its
//   first result shows on rsp_*; results leave the queue one per cycle while
//   rsp_ready is high. A request causes zero to five results, so sustained rate
//   is set by the one-result-per-cycle output port.
// req_ready stays high while the input register is free or the 8-entry result
//   queue has room for a full five-result burst; a stalled receiver fills the
//   queue and then holds req_ready low until space frees up.
// Reset: phase idle, queue empty, flash_kib 4096.
// ---------------------------------------------------------------------------
module spi_nor_program_erase_sequencer_unit
   import snpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TYPE_W-1:0]    req_type,
   input  logic [OFFSET_W-1:0]  req_offset,
   input  logic [LENGTH_W-1:0]  req_length,
   input  logic [BYTE_W-1:0]    req_byte_in,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [BYTE_W-1:0]    rsp_spi_byte,
   output logic                 rsp_last,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [KIB_W-1:0]     csr_wdata
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   req_item_type            in_item_ff;
   seq_state_type           state_ff;
   seq_state_type           state_nxt;
   logic [KIB_W-1:0]        flash_kib_ff;
   logic [RSP_CNT_W-1:0]    step_count;
   rsp_item_type            step_items [MAX_RSP];
   logic [RSP_CNT_W-1:0]    push_count;
   logic [FIFO_CNT_W-1:0]   fifo_count;
   rsp_item_type            fifo_head;
   logic                    room;
   logic                    process;
   logic                    req_accept;
   logic                    pop;

   assign room       = fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RSP);
   assign process    = in_valid_ff && room;
   assign req_ready  = !in_valid_ff || process;
   assign req_accept = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !process);
   assign push_count = process ? step_count : '0;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         flash_kib_ff <= FLASH_KIB_RESET;
         state_ff     <= '{phase: PH_IDLE, erasing: 1'b0, cur_address: '0,
                           bytes_remaining: '0, chunk_left: '0};
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            flash_kib_ff <= csr_wdata;
         end
         // advance state only when the transaction's results are queued
         if (process) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= '{req_type: req_type, offset: req_offset,
                         length: req_length, byte_in: req_byte_in};
      end
   end

   snpe_step u_step (
      .cur_state (state_ff),
      .flash_kib (flash_kib_ff),
      .req       (in_item_ff),
      .nxt_state (state_nxt),
      .rsp_count (step_count),
      .rsp_items (step_items)
   );

   snpe_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_items (step_items),
      .pop        (pop),
      .head       (fifo_head),
      .count      (fifo_count)
   );

   assign rsp_valid    = fifo_count != '0;
   assign pop          = rsp_valid && rsp_ready;
   assign rsp_kind     = fifo_head.kind;
   assign rsp_spi_byte = fifo_head.spi_byte;
   assign rsp_last     = fifo_head.last;

endmodule
